[hdl/deque_with_search_delete_assert.svh]
// Assertion macros shared by the deque checker.
`ifndef DEQUE_WITH_SEARCH_DELETE_ASSERT_SVH
`define DEQUE_WITH_SEARCH_DELETE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define DQSD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DQSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dqsd_pkg.sv]
// Shared types and constants of the double-ended queue.
package dqsd_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DELETE     = 3'd4,
        OP_SEARCH     = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_ABSENT = 2'd3
    } status_t;

endpackage

[hdl/dqsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dqsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/deque_with_search_delete.sv]
// Bounded double-ended queue of signed 32-bit values with search and delete.
//
// Usage:
//   One request enters on the s_ channel; exactly one result leaves on the
//   m_ channel for each request, in order. Requests: push front/back, pop
//   front/back, delete the first entry equal to a value, search for a value.
//   Entries live in a circular buffer RAM (head pointer plus count); pushes
//   write one RAM word, pops only move the head or count, and neither scans.
// Sequencing: push, pop and unused codes go straight to the result state.
//   search or delete walks the entries from the front, one at a time, on
//     the single read port and 32-bit comparator (read state, then compare
//     state); a delete hit then moves each later entry one place forward
//     (read state, then write state).
//   search or delete miss: compares every entry, then reports absent.
// Throughput: one request at a time; s_tready is high only while the
//   sequencer is idle, from the cycle after the result is loaded.
// Reset: synchronous active-low aresetn empties the queue (count and head
//   cleared) and drops m_tvalid; the RAM contents are not cleared.
// Stall: a result waits in the output register while m_tready is low; a
//   finished request then holds the sequencer until the register drains.
module deque_with_search_delete #(
    parameter int DEPTH = dqsd_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] op, [34:3] value, [39:35] zero
    input  logic [dqsd_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [2] found, [7:3] count
    output logic [dqsd_pkg::M_TDATA_W-1:0]  m_tdata
);

    import dqsd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESP
    } state_t;

    // Logical position to RAM address: (base + off) mod DEPTH.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          idx_reg, idx_next;
    status_t                status_reg, status_next;
    logic                   found_reg, found_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_W-1:0]     wr_data;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_W-1:0]     rd_data;

    logic                   in_fire;
    op_t                    in_op;
    logic [VALUE_W-1:0]     in_value;
    logic [CW-1:0]          idx_inc;

    assign in_fire  = s_tvalid && s_tready;
    assign in_op    = op_t'(s_tdata[OP_W-1:0]);
    assign in_value = s_tdata[OP_W +: VALUE_W];
    assign idx_inc  = idx_reg + CW'(1);

    dqsd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        value_next    = value_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = head_reg;
        wr_data       = in_value;
        rd_addr       = phys(head_reg, idx_reg[AW-1:0]);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    status_next = STAT_OK;
                    found_next  = 1'b0;
                    state_next  = ST_RESP;
                    unique case (in_op)
                        OP_PUSH_FRONT: begin
                            if (count_reg == DEPTH_C) begin
                                status_next = STAT_FULL;
                            end else begin
                                head_next  = (head_reg == '0) ? LAST_A
                                                              : head_reg - AW'(1);
                                wr_en      = 1'b1;
                                wr_addr    = head_next;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (count_reg == DEPTH_C) begin
                                status_next = STAT_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = phys(head_reg, count_reg[AW-1:0]);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                head_next  = (head_reg == LAST_A) ? '0
                                                                  : head_reg + AW'(1);
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_DELETE, OP_SEARCH: begin
                            op_next    = in_op;
                            value_next = in_value;
                            idx_next   = '0;
                            state_next = ST_SCAN_RD;
                        end
                        default: begin
                            // unused codes: no change, plain ok
                        end
                    endcase
                end
            end
            ST_SCAN_RD: begin
                if (idx_reg == count_reg) begin
                    status_next = STAT_ABSENT;
                    state_next  = ST_RESP;
                end else begin
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (rd_data == value_reg) begin
                    found_next = 1'b1;
                    state_next = (op_reg == OP_DELETE) ? ST_SHIFT_RD : ST_RESP;
                end else begin
                    idx_next   = idx_inc;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SHIFT_RD: begin
                // close the gap: entry idx+1 moves to idx
                rd_addr = phys(head_reg, idx_inc[AW-1:0]);
                if (idx_inc == count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                wr_en      = 1'b1;
                wr_addr    = phys(head_reg, idx_reg[AW-1:0]);
                wr_data    = rd_data;
                idx_next   = idx_inc;
                state_next = ST_SHIFT_RD;
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {COUNT_W'(count_reg), found_reg, status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg      <= op_next;
        value_reg   <= value_next;
        idx_reg     <= idx_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hdl/dqsd_chk.sv]
// Port-level checker for the deque, bound to the top level.
`include "deque_with_search_delete_assert.svh"

module dqsd_chk #(
    parameter int DEPTH = dqsd_pkg::DEPTH_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dqsd_pkg::M_TDATA_W-1:0]  m_tdata
);

    import dqsd_pkg::*;

    logic    res_found;
    status_t res_status;
    logic [COUNT_W-1:0] res_count;

    assign res_status = status_t'(m_tdata[STATUS_W-1:0]);
    assign res_found  = m_tdata[STATUS_W];
    assign res_count  = m_tdata[STATUS_W+1 +: COUNT_W];

    // one request in flight: no second accept right after one
    `DQSD_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request accepted while busy")

    `DQSD_ASSERT_NOW(a_found_ok, aclk, aresetn, m_tvalid && res_found, res_status == STAT_OK, "found with non-ok status")

    `DQSD_ASSERT_NOW(a_empty_count, aclk, aresetn, m_tvalid && (res_status == STAT_EMPTY), res_count == '0, "empty status with nonzero count")

    `DQSD_ASSERT_NOW(a_count_bound, aclk, aresetn, m_tvalid, int'(res_count) <= DEPTH, "count above depth")

    `DQSD_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

endmodule

bind deque_with_search_delete dqsd_chk #(.DEPTH(DEPTH)) u_dqsd_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
